### hdl/sbda_pkg.sv
// Shared types and constants for the signed binary to decimal text converter.
`default_nettype none

package sbda_pkg;

   localparam int unsigned DIGIT_W = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Double-dabble correction: a digit of 5 or more gets 3 added before the shift.
   localparam logic [DIGIT_W-1:0] ADD3_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] ADD3_STEP  = 4'd3;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;       // take the input value, start a conversion
      logic shift;      // one double-dabble step
      logic drop_digit; // shift the top BCD digit out
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic conv_done;  // all magnitude bits shifted in
      logic top_zero;   // top BCD digit is zero
      logic last_digit; // one digit left in the run
      logic negative;   // input was negative
   } sts_type;

endpackage

`default_nettype wire

### hdl/sbda_if.sv
// Valid/ready channel interfaces for the converter's input and result items.
`default_nettype none

interface sbda_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sbda_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

### hdl/sbda_dpath.sv
// Datapath: magnitude shifter, BCD register with add-3 correction, bit and digit counters.
`default_nettype none

module sbda_dpath
   import sbda_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic signed [VALUE_WIDTH-1:0] value,
   input  wire cmd_type                       cmd,
   output      sts_type                       sts,
   output      logic [7:0]                    digit_char
);

   // Decimal digits of 2^VALUE_WIDTH, log10(2) ~ 1233/4096.
   localparam int unsigned DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int unsigned BCD_W   = DIGITS * DIGIT_W;
   localparam int unsigned BCNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned DCNT_W  = $clog2(DIGITS + 1);

   logic [VALUE_WIDTH-1:0] mag_ff,  mag_in;
   logic [BCD_W-1:0]       bcd_ff,  bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [BCNT_W-1:0]      bcnt_ff, bcnt_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic                   neg_ff,  neg_in;
   logic [VALUE_WIDTH-1:0] raw;

   assign raw = value;

   // add-3 on every digit, independent per digit
   always_comb begin
      logic [DIGIT_W-1:0] nib;
      for (int i = 0; i < DIGITS; i++) begin
         nib = bcd_ff[i*DIGIT_W +: DIGIT_W];
         bcd_adj[i*DIGIT_W +: DIGIT_W] = (nib >= ADD3_LIMIT) ? nib + ADD3_STEP : nib;
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      bcnt_in = bcnt_ff;
      dcnt_in = dcnt_ff;
      neg_in  = neg_ff;
      if (cmd.load) begin
         neg_in  = raw[VALUE_WIDTH-1];
         mag_in  = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
         bcd_in  = '0;
         bcnt_in = BCNT_W'(VALUE_WIDTH);
         dcnt_in = DCNT_W'(DIGITS);
      end else if (cmd.shift) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in  = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bcnt_in = bcnt_ff - 1'b1;
      end else if (cmd.drop_digit) begin
         bcd_in  = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         dcnt_in = dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      bcnt_ff <= bcnt_in;
      dcnt_ff <= dcnt_in;
      neg_ff  <= neg_in;
   end

   assign sts.conv_done  = (bcnt_ff == '0);
   assign sts.top_zero   = (bcd_ff[BCD_W-1 -: DIGIT_W] == '0);
   assign sts.last_digit = (dcnt_ff == DCNT_W'(1));
   assign sts.negative   = neg_ff;

   assign digit_char = CHAR_ZERO + 8'(bcd_ff[BCD_W-1 -: DIGIT_W]);

endmodule

`default_nettype wire

### hdl/sbda_ctrl.sv
// Controller: sequences load, conversion, leading-zero trim and character output.
`default_nettype none

module sbda_ctrl
   import sbda_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      logic    sel_minus,
   output      cmd_type cmd,
   input  wire sts_type sts
);

   typedef enum logic [2:0] {
      IDLE,
      CONVERT,
      TRIM,
      SIGN,
      DIGIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            if (sts.conv_done) begin
               state_in = TRIM;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         TRIM: begin
            if (sts.top_zero && !sts.last_digit) begin
               cmd.drop_digit = 1'b1;
            end else begin
               state_in = sts.negative ? SIGN : DIGIT;
            end
         end
         SIGN: begin
            if (rsp_ready) begin
               state_in = DIGIT;
            end
         end
         DIGIT: begin
            if (rsp_ready) begin
               if (sts.last_digit) begin
                  state_in = IDLE;
               end else begin
                  cmd.drop_digit = 1'b1;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == SIGN) || (state_ff == DIGIT);
   assign sel_minus = (state_ff == SIGN);

endmodule

`default_nettype wire

### hdl/signed_binary_to_decimal_ascii_core.sv
// Top level of the signed binary to decimal ASCII text converter.
`default_nettype none

// Converts one signed VALUE_WIDTH-bit integer per input item into its decimal text,
// one ASCII character per result item, most significant digit first. Negative values
// get a leading '-'; zero gives a single '0'; the most negative value converts exactly
// (its magnitude is handled as unsigned). The final character of each run has last = 1.
// One item at a time: req ready is high only while idle. Per item the block loads the
// value, runs VALUE_WIDTH double-dabble steps (one magnitude bit each), trims leading
// zero digits, then emits the '-' when negative and the digits, each character held
// until the result side is ready. Trimmed zeros and emitted digits always add up to
// DIGITS. The double-dabble loop sets most of the time per item; the result side
// holding off lengthens it.

module signed_binary_to_decimal_ascii_core
   import sbda_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sbda_req_if.sink    req_chan,
   sbda_rsp_if.source  rsp_chan
);

   cmd_type    cmd;
   sts_type    sts;
   logic       sel_minus;
   logic [7:0] digit_char;

   sbda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sel_minus (sel_minus),
      .cmd       (cmd),
      .sts       (sts)
   );

   sbda_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .value      (req_chan.value),
      .cmd        (cmd),
      .sts        (sts),
      .digit_char (digit_char)
   );

   // Result payload comes straight off registers: sign or the top BCD digit.
   assign rsp_chan.char_code = sel_minus ? CHAR_MINUS : digit_char;
   assign rsp_chan.last      = !sel_minus && sts.last_digit;

   // Sign character is never the end of a run.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && sel_minus) |-> !rsp_chan.last)
      else $error("sign character marked last");

   // No new item while results are pending.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("input ready while emitting");

   // After an accept the block is busy next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input ready right after accept");

   // Digit characters are decimal digits.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !sel_minus) |->
         (rsp_chan.char_code >= CHAR_ZERO && rsp_chan.char_code <= CHAR_ZERO + 8'd9))
      else $error("digit character out of range");

endmodule

`default_nettype wire
